### rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int KIND_W = 2;
	localparam int CHAR_W = 8;
	localparam int COLOR_W = 4;
	localparam int INDEX_W = 11;
	localparam int ATTR_W = 8;
	localparam int CELL_W = CHAR_W + ATTR_W;

	localparam logic [KIND_W-1:0] KIND_PUT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NULL = 8'd0;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	localparam logic REG_FORE_COLOR = 1'b0;
	localparam logic REG_BACK_COLOR = 1'b1;

	typedef struct packed {
		logic load;
		logic put;
		logic tab_put;
		logic newline;
		logic sweep_start;
		logic sweep_clear;
		logic sweep_step;
		logic resp_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic is_null;
		logic is_newline;
		logic is_tab;
		logic tab_cross;
		logic col_zero;
		logic phase_last;
		logic adv_wrap;
		logic nl_wrap;
		logic sweep_last;
		logic out_busy;
	} tcw_status_t;

endpackage

### rtl/tcw_if.sv
// Item channel interfaces for the text console writer.
interface tcw_in_if import tcw_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] char_code;
	logic [COLOR_W-1:0] clear_color;
	logic [INDEX_W-1:0] cell_index;

	modport source (output valid, kind, char_code, clear_color, cell_index, input ready);
	modport sink (input valid, kind, char_code, clear_color, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
	logic valid;
	logic ready;
	logic [INDEX_W-1:0] cursor_pos;
	logic [CHAR_W-1:0] cell_char;
	logic [ATTR_W-1:0] cell_attr;

	modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
	modport sink (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

### rtl/text_console_writer_unit.sv
// Put/newline/null/read: accept, DECODE, RESP, result register; a tab writes its pad cells in TAB.
// Scroll and clear sweep the screen store once, reading and writing through separate RAM ports.
// One item at a time; the next item is taken the cycle after the result register is loaded.
// Reset: cursor 0, colours 7/0; a clearing pass over all COLUMNS*ROWS cells blanks the store
// before the first item is accepted (configuration writes are taken throughout).
// Top level of the text console writer.
module text_console_writer_unit import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_STOP = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	tcw_in_if.sink             in_ch,
	tcw_out_if.source          out_ch,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [COLOR_W-1:0] cfg_data
);

	tcw_cmd_t    cmd;
	tcw_status_t status;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	tcw_dp #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_kind        (in_ch.kind),
		.in_char_code   (in_ch.char_code),
		.in_clear_color (in_ch.clear_color),
		.in_cell_index  (in_ch.cell_index),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_cursor_pos (out_ch.cursor_pos),
		.out_cell_char  (out_ch.cell_char),
		.out_cell_attr  (out_ch.cell_attr)
	);

endmodule

### rtl/tcw_ram.sv
// Generic single write port RAM with registered read.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/tcw_ctrl.sv
// Controller state machine for the text console writer.
module tcw_ctrl import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  tcw_status_t status,
	output tcw_cmd_t    cmd
);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_TAB = 3'd3;
	localparam logic [2:0] ST_SWEEP = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_RESP;
				case (status.kind)
					KIND_PUT: begin
						if (status.is_null) begin
							state_d = ST_RESP;
						end else if (status.is_newline || (status.is_tab && status.tab_cross)) begin
							cmd.newline = 1'b1;
							if (status.nl_wrap) begin
								cmd.sweep_start = 1'b1;
								state_d = ST_SWEEP;
							end
						end else if (status.is_tab) begin
							if (!status.col_zero) begin
								state_d = ST_TAB;
							end
						end else begin
							cmd.put = 1'b1;
							if (status.adv_wrap) begin
								cmd.sweep_start = 1'b1;
								state_d = ST_SWEEP;
							end
						end
					end
					KIND_CLEAR: begin
						cmd.sweep_start = 1'b1;
						cmd.sweep_clear = 1'b1;
						state_d = ST_SWEEP;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_TAB: begin
				cmd.tab_put = 1'b1;
				if (status.phase_last) begin
					state_d = ST_RESP;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!status.out_busy) begin
					cmd.resp_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/tcw_dp.sv
// Datapath for the text console writer: cursor, sweep counter, screen store, result register.
module tcw_dp import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_STOP = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcw_cmd_t            cmd,
	output tcw_status_t         status,
	input  logic [KIND_W-1:0]   in_kind,
	input  logic [CHAR_W-1:0]   in_char_code,
	input  logic [COLOR_W-1:0]  in_clear_color,
	input  logic [INDEX_W-1:0]  in_cell_index,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [COLOR_W-1:0]  cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [INDEX_W-1:0]  out_cursor_pos,
	output logic [CHAR_W-1:0]   out_cell_char,
	output logic [ATTR_W-1:0]   out_cell_attr
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = $clog2(CELLS);
	localparam int CLW = $clog2(COLUMNS);
	localparam int PW = $clog2(TAB_STOP);
	localparam int TW = CLW + 2;
	localparam int CMPW = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_ROW = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] ROW_STEP = AW'(COLUMNS);

	logic [KIND_W-1:0]  kind_q;
	logic [CHAR_W-1:0]  char_q;
	logic [COLOR_W-1:0] ccol_q;
	logic [INDEX_W-1:0] idx_q;
	logic [COLOR_W-1:0] fore_q;
	logic [COLOR_W-1:0] back_q;

	logic [AW-1:0]  cursor_q;
	logic [AW-1:0]  rs_q;
	logic [CLW-1:0] col_q;
	logic [PW-1:0]  phase_q;

	logic [AW-1:0]     sw_q;
	logic              move_mode_q;
	logic [ATTR_W-1:0] fill_attr_q;
	logic              wv_s1;
	logic [AW-1:0]     wa_s1;
	logic              move_s1;

	logic              out_valid_q;
	logic [INDEX_W-1:0] out_cursor_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [ATTR_W-1:0] out_attr_q;

	logic              sw_moves;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;
	logic [ATTR_W-1:0] cur_attr;
	logic              rd_ok;
	logic [TW-1:0]     tab_end;

	assign cur_attr = {back_q, fore_q};
	assign sw_moves = sw_q < LAST_ROW;
	assign tab_end = TW'(col_q) + TW'(TAB_STOP) - TW'(phase_q);
	assign rd_ok = (kind_q == KIND_READ) && (CMPW'(idx_q) < CMPW'(CELLS));

	always_comb begin
		status.kind = kind_q;
		status.is_null = char_q == CH_NULL;
		status.is_newline = char_q == CH_NEWLINE;
		status.is_tab = char_q == CH_TAB;
		status.tab_cross = tab_end >= TW'(COLUMNS);
		status.col_zero = col_q == '0;
		status.phase_last = phase_q == PW'(TAB_STOP - 1);
		status.adv_wrap = cursor_q == LAST_CELL;
		status.nl_wrap = rs_q == LAST_ROW;
		status.sweep_last = sw_q == LAST_CELL;
		status.out_busy = out_valid_q && !out_ready;
	end

	always_comb begin
		ram_raddr = AW'(CMPW'(idx_q));
		if (cmd.sweep_step) begin
			ram_raddr = sw_moves ? sw_q + ROW_STEP : sw_q;
		end
		ram_we = 1'b0;
		ram_waddr = cursor_q;
		ram_wdata = {CH_SPACE, cur_attr};
		if (wv_s1) begin
			ram_we = 1'b1;
			ram_waddr = wa_s1;
			ram_wdata = move_s1 ? ram_rdata : {CH_SPACE, fill_attr_q};
		end else if (cmd.put || cmd.tab_put) begin
			ram_we = 1'b1;
			ram_wdata = {cmd.put ? char_q : CH_SPACE, cur_attr};
		end
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			char_q <= in_char_code;
			ccol_q <= in_clear_color;
			idx_q <= in_cell_index;
		end
		wa_s1 <= sw_q;
		move_s1 <= move_mode_q && sw_moves;
		if (cmd.resp_load) begin
			out_cursor_q <= INDEX_W'(cursor_q);
			out_char_q <= rd_ok ? ram_rdata[CELL_W-1:ATTR_W] : '0;
			out_attr_q <= rd_ok ? ram_rdata[ATTR_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q <= 4'd7;
			back_q <= 4'd0;
			cursor_q <= '0;
			rs_q <= '0;
			col_q <= '0;
			phase_q <= '0;
			sw_q <= '0;
			move_mode_q <= 1'b0;
			fill_attr_q <= '0;
			wv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FORE_COLOR: fore_q <= cfg_data;
					REG_BACK_COLOR: back_q <= cfg_data;
					default: ;
				endcase
			end
			wv_s1 <= cmd.sweep_step;
			if (cmd.sweep_step) begin
				sw_q <= sw_q + 1'b1;
			end
			if (cmd.sweep_start) begin
				sw_q <= '0;
				move_mode_q <= !cmd.sweep_clear;
				fill_attr_q <= cmd.sweep_clear ? {ccol_q, {COLOR_W{1'b0}}} : '0;
			end
			if (cmd.sweep_start && cmd.sweep_clear) begin
				cursor_q <= '0;
				rs_q <= '0;
				col_q <= '0;
				phase_q <= '0;
			end else if (cmd.newline) begin
				col_q <= '0;
				phase_q <= '0;
				if (rs_q == LAST_ROW) begin
					cursor_q <= LAST_ROW;
				end else begin
					rs_q <= rs_q + ROW_STEP;
					cursor_q <= rs_q + ROW_STEP;
				end
			end else if (cmd.put || cmd.tab_put) begin
				if (cursor_q == LAST_CELL) begin
					cursor_q <= LAST_ROW;
					col_q <= '0;
					phase_q <= '0;
				end else if (col_q == CLW'(COLUMNS - 1)) begin
					cursor_q <= cursor_q + 1'b1;
					rs_q <= rs_q + ROW_STEP;
					col_q <= '0;
					phase_q <= '0;
				end else begin
					cursor_q <= cursor_q + 1'b1;
					col_q <= col_q + 1'b1;
					phase_q <= (phase_q == PW'(TAB_STOP - 1)) ? '0 : phase_q + 1'b1;
				end
			end
			if (cmd.resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_cursor_pos = out_cursor_q;
	assign out_cell_char = out_char_q;
	assign out_cell_attr = out_attr_q;

endmodule
